FILE: hw/rtl/pbcd_pkg.sv
// Package for the pointer barrier crossing detector.
// Holds table sizes, action and status codes, state enum and stored entry types.
// No dependencies.
package pbcd_pkg;

    localparam int MaxBarriers = 16;
    localparam int MaxSessions = 8;
    localparam int IdxW = $clog2(MaxBarriers);
    localparam int CntW = $clog2(MaxBarriers + 1);
    localparam int EntryW = 95;

    localparam logic [1:0] ActAdd = 2'd0;
    localparam logic [1:0] ActClear = 2'd1;
    localparam logic [1:0] ActMotion = 2'd2;

    localparam logic [1:0] StatDone = 2'd0;
    localparam logic [1:0] StatHit = 2'd1;
    localparam logic [1:0] StatFull = 2'd2;

    typedef struct packed {
        logic [2:0]  session;
        logic [31:0] id;
        logic [14:0] x1;
        logic [14:0] y1;
        logic [14:0] x2;
        logic [14:0] y2;
    } entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD,
        ST_RDWAIT,
        ST_CLR,
        ST_M0,
        ST_M1,
        ST_M2,
        ST_M3,
        ST_M4,
        ST_M5,
        ST_M6,
        ST_DECIDE,
        ST_DONE
    } state_t;

    // Operand selectors for the shared multiplier.
    typedef enum logic [2:0] {
        MS_S1X_S2Y,
        MS_S2X_S1Y,
        MS_S1X_DY,
        MS_S1Y_DX,
        MS_S2X_DY,
        MS_S2Y_DX
    } msel_t;

endpackage

FILE: hw/rtl/pbcd_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module pbcd_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hw/rtl/pbcd_mul.sv
// Shared signed multiplier with registered product for the crossing test.
// No dependencies.
module pbcd_mul (
    input  logic               clk,
    input  logic signed [25:0] a,
    input  logic signed [25:0] b,
    output logic signed [51:0] prod_reg
);

    // Operands are 26 bits: one 26x26 multiply per cycle, then a register.
    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

endmodule

FILE: hw/rtl/pointer_barrier_crossing_detector.sv
// Pointer barrier crossing detector, top level: sequencer, barrier RAM, shared multiplier.
// Depends on pbcd_pkg, pbcd_ram and pbcd_mul.
// Add and ignored actions go straight to the finishing state; clear and motion scan the N stored
// barriers, a disabled one being skipped after its read, at a pace set by the one RAM read port
// and the single multiplier used six times per barrier.
// One word at a time, busy until the strobe; reset empties the table and the mask.
module pointer_barrier_crossing_detector (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [0:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         action,
    input  logic [2:0]         session,
    input  logic [31:0]        barrier_id,
    input  logic [14:0]        barrier_x1,
    input  logic [14:0]        barrier_y1,
    input  logic [14:0]        barrier_x2,
    input  logic [14:0]        barrier_y2,
    input  logic signed [23:0] pos_x,
    input  logic signed [23:0] pos_y,
    input  logic signed [23:0] delta_x,
    input  logic signed [23:0] delta_y,
    output logic               done,
    output logic [1:0]         status,
    output logic [2:0]         hit_session,
    output logic [31:0]        hit_barrier,
    output logic [4:0]         barrier_count
);

    localparam int IW = pbcd_pkg::IdxW;
    localparam int CW = pbcd_pkg::CntW;

    // The only register is the session enable mask at address zero.
    logic [7:0] mask_reg;
    assign pready = 1'b1;
    assign prdata = {24'd0, mask_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else if (psel && penable && pwrite && paddr == 1'b0)
        begin
            mask_reg <= pwdata[7:0];
        end
    end

    pbcd_pkg::state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] rd_reg, rd_next;       // read index during scans
    logic [CW-1:0] wr_reg, wr_next;       // compaction write index
    logic [1:0]    act_reg, act_next;
    logic [2:0]    sess_reg, sess_next;
    logic [1:0]    stat_reg, stat_next;
    logic [2:0]    hs_reg, hs_next;
    logic [31:0]   hb_reg, hb_next;
    logic          done_reg, done_next;

    // Motion segment, latched at start. Delta is s2 negated: s2 = -delta.
    logic signed [23:0] px_reg, py_reg, dlx_reg, dly_reg;
    logic signed [52:0] den_reg, den_next, ns_reg, ns_next, nt_reg, nt_next;
    logic signed [52:0] acc_reg, acc_next;

    pbcd_pkg::entry_t ent_reg, rdata, wdata;
    logic           we;
    logic [IW-1:0]  waddr, raddr;

    pbcd_ram #(.Width(pbcd_pkg::EntryW), .Depth(pbcd_pkg::MaxBarriers)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Geometry of the current barrier, all in Q17.8.
    logic signed [25:0] s1x, s1y, dx, dy, s2x, s2y;
    assign s1x = $signed({3'd0, ent_reg.x2, 8'd0}) - $signed({3'd0, ent_reg.x1, 8'd0});
    assign s1y = $signed({3'd0, ent_reg.y2, 8'd0}) - $signed({3'd0, ent_reg.y1, 8'd0});
    assign dx  = $signed({3'd0, ent_reg.x1, 8'd0}) - 26'(px_reg);
    assign dy  = $signed({3'd0, ent_reg.y1, 8'd0}) - 26'(py_reg);
    assign s2x = -26'(dlx_reg);
    assign s2y = -26'(dly_reg);

    pbcd_pkg::msel_t msel;
    logic signed [25:0] ma, mb;
    logic signed [51:0] prod;

    always_comb
    begin
        unique case (msel)
            pbcd_pkg::MS_S1X_S2Y: begin ma = s1x; mb = s2y; end
            pbcd_pkg::MS_S2X_S1Y: begin ma = s2x; mb = s1y; end
            pbcd_pkg::MS_S1X_DY:  begin ma = s1x; mb = dy;  end
            pbcd_pkg::MS_S1Y_DX:  begin ma = s1y; mb = dx;  end
            pbcd_pkg::MS_S2X_DY:  begin ma = s2x; mb = dy;  end
            default:              begin ma = s2y; mb = dx;  end
        endcase
    end

    pbcd_mul u_mul (
        .clk      (clk),
        .a        (ma),
        .b        (mb),
        .prod_reg (prod)
    );

    logic signed [52:0] prod_x;
    assign prod_x = 53'(prod);

    function automatic logic in_unit(logic signed [52:0] num, logic signed [52:0] den);
        if (den > 0)
            return num >= 0 && num <= den;
        return num <= 0 && num >= den;
    endfunction

    logic enabled;
    assign enabled = (32'(ent_reg.session) < 32'(pbcd_pkg::MaxSessions))
                     && mask_reg[ent_reg.session];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pbcd_pkg::ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_reg   <= rd_next;
        wr_reg   <= wr_next;
        act_reg  <= act_next;
        sess_reg <= sess_next;
        stat_reg <= stat_next;
        hs_reg   <= hs_next;
        hb_reg   <= hb_next;
        den_reg  <= den_next;
        ns_reg   <= ns_next;
        nt_reg   <= nt_next;
        acc_reg  <= acc_next;
        if (state_reg == pbcd_pkg::ST_RDWAIT)
        begin
            ent_reg <= rdata;
        end
        if (state_reg == pbcd_pkg::ST_IDLE && start)
        begin
            px_reg  <= pos_x;
            py_reg  <= pos_y;
            dlx_reg <= delta_x;
            dly_reg <= delta_y;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        rd_next    = rd_reg;
        wr_next    = wr_reg;
        act_next   = act_reg;
        sess_next  = sess_reg;
        stat_next  = stat_reg;
        hs_next    = hs_reg;
        hb_next    = hb_reg;
        den_next   = den_reg;
        ns_next    = ns_reg;
        nt_next    = nt_reg;
        acc_next   = acc_reg;
        done_next  = 1'b0;
        we         = 1'b0;
        waddr      = count_reg[IW-1:0];
        wdata      = '{session: session, id: barrier_id, x1: barrier_x1,
                       y1: barrier_y1, x2: barrier_x2, y2: barrier_y2};
        raddr      = rd_reg[IW-1:0];
        msel       = pbcd_pkg::MS_S1X_S2Y;

        unique case (state_reg)
            pbcd_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    act_next  = action;
                    sess_next = session;
                    stat_next = pbcd_pkg::StatDone;
                    hs_next   = '0;
                    hb_next   = '0;
                    rd_next   = '0;
                    wr_next   = '0;
                    unique case (action) inside
                        pbcd_pkg::ActAdd:
                        begin
                            if (32'(count_reg) >= 32'(pbcd_pkg::MaxBarriers))
                            begin
                                stat_next = pbcd_pkg::StatFull;
                            end
                            else
                            begin
                                we         = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                            state_next = pbcd_pkg::ST_DONE;
                        end
                        pbcd_pkg::ActClear, pbcd_pkg::ActMotion:
                            state_next = pbcd_pkg::ST_RD;
                        default:
                            state_next = pbcd_pkg::ST_DONE;
                    endcase
                end
            end
            pbcd_pkg::ST_RD:
            begin
                if (rd_reg >= count_reg)
                begin
                    if (act_reg == pbcd_pkg::ActClear)
                    begin
                        count_next = wr_reg;
                    end
                    state_next = pbcd_pkg::ST_DONE;
                end
                else
                begin
                    state_next = pbcd_pkg::ST_RDWAIT;
                end
            end
            pbcd_pkg::ST_RDWAIT:
                state_next = (act_reg == pbcd_pkg::ActClear) ? pbcd_pkg::ST_CLR
                                                               : pbcd_pkg::ST_M0;
            pbcd_pkg::ST_CLR:
            begin
                if (ent_reg.session != sess_reg)
                begin
                    we      = 1'b1;
                    waddr   = wr_reg[IW-1:0];
                    wdata   = ent_reg;
                    wr_next = wr_reg + 1'b1;
                end
                rd_next    = rd_reg + 1'b1;
                state_next = pbcd_pkg::ST_RD;
            end
            pbcd_pkg::ST_M0:
            begin
                if (!enabled)
                begin
                    rd_next    = rd_reg + 1'b1;
                    state_next = pbcd_pkg::ST_RD;
                end
                else
                begin
                    msel       = pbcd_pkg::MS_S1X_S2Y;
                    state_next = pbcd_pkg::ST_M1;
                end
            end
            pbcd_pkg::ST_M1:
            begin
                msel       = pbcd_pkg::MS_S2X_S1Y;
                acc_next   = prod_x;
                state_next = pbcd_pkg::ST_M2;
            end
            pbcd_pkg::ST_M2:
            begin
                msel       = pbcd_pkg::MS_S1X_DY;
                den_next   = acc_reg - prod_x;
                state_next = pbcd_pkg::ST_M3;
            end
            pbcd_pkg::ST_M3:
            begin
                msel       = pbcd_pkg::MS_S1Y_DX;
                acc_next   = prod_x;
                state_next = pbcd_pkg::ST_M4;
            end
            pbcd_pkg::ST_M4:
            begin
                msel       = pbcd_pkg::MS_S2X_DY;
                ns_next    = acc_reg - prod_x;
                state_next = pbcd_pkg::ST_M5;
            end
            pbcd_pkg::ST_M5:
            begin
                msel       = pbcd_pkg::MS_S2Y_DX;
                acc_next   = prod_x;
                state_next = pbcd_pkg::ST_M6;
            end
            pbcd_pkg::ST_M6:
            begin
                nt_next    = acc_reg - prod_x;
                state_next = pbcd_pkg::ST_DECIDE;
            end
            pbcd_pkg::ST_DECIDE:
            begin
                if (den_reg != 0 && in_unit(ns_reg, den_reg) && in_unit(nt_reg, den_reg))
                begin
                    stat_next  = pbcd_pkg::StatHit;
                    hs_next    = ent_reg.session;
                    hb_next    = ent_reg.id;
                    state_next = pbcd_pkg::ST_DONE;
                end
                else
                begin
                    rd_next    = rd_reg + 1'b1;
                    state_next = pbcd_pkg::ST_RD;
                end
            end
            pbcd_pkg::ST_DONE:
            begin
                done_next  = 1'b1;
                state_next = pbcd_pkg::ST_IDLE;
            end
            default:
                state_next = pbcd_pkg::ST_IDLE;
        endcase
    end

    // Result word registered and held until a new start; done is a registered strobe.
    assign busy          = (state_reg != pbcd_pkg::ST_IDLE);
    assign done          = done_reg;
    assign status        = stat_reg;
    assign hit_session   = hs_reg;
    assign hit_barrier   = hb_reg;
    assign barrier_count = 5'(count_reg);

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= 32'(pbcd_pkg::MaxBarriers))
        else $error("barrier count beyond table size");
    a_done_after_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg) == pbcd_pkg::ST_DONE)
        else $error("strobe without finishing state");
    a_wr_behind_rd: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == pbcd_pkg::ST_CLR |-> wr_reg <= rd_reg)
        else $error("compaction write passed read");
    a_hit_fields: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && status != pbcd_pkg::StatHit |-> hit_barrier == 0 && hit_session == 0)
        else $error("hit fields set without hit");
endmodule
